// File: src/mer_pkg.sv
// Shared constants for the midpoint ellipse rasteriser.
// Holds port geometry, register indexes, phase codes, output mode codes and quadrant codes.
// Has no dependencies; the top level refers to it by scoped names.
package mer_pkg;

    // Configuration port geometry.
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int REG_SEL_BIT = 2;

    // Register indexes, decoded from the word-select bit of the address.
    localparam logic REG_RADIUS_X = 1'b0;
    localparam logic REG_RADIUS_Y = 1'b1;

    // Drawing phase of the ellipse.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_REG1 = 2'd1;
    localparam logic [1:0] PH_REG2 = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Kind of result run that the output register is sending.
    localparam logic [1:0] MODE_TOP  = 2'd0;
    localparam logic [1:0] MODE_QUAD = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // Quadrant order of the four symmetric points.
    localparam logic [1:0] Q_PP = 2'd0;
    localparam logic [1:0] Q_PN = 2'd1;
    localparam logic [1:0] Q_NN = 2'd2;
    localparam logic [1:0] Q_NP = 2'd3;

endpackage

// File: src/mer_if.sv
// Valid/ready channel interfaces of the midpoint ellipse rasteriser.
// mer_in_if carries the request bit, mer_out_if carries one pixel result.
// No dependencies.
interface mer_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink (input valid, input start_req, output ready);
endinterface

interface mer_out_if #(parameter int COORD_BITS = 10);
    logic                  valid;
    logic                  ready;
    logic signed [COORD_BITS:0] point_x;
    logic signed [COORD_BITS:0] point_y;
    logic                  last;
    logic                  done_res;

    modport source (output valid, output point_x, output point_y, output last,
                    output done_res, input ready);
    modport sink (input valid, input point_x, input point_y, input last,
                  input done_res, output ready);
endinterface

// File: src/mer_mul.sv
// Shared unsigned multiplier of the ellipse rasteriser, with a registered product.
// The product is truncated or zero-extended to the decision width.
// No dependencies.
module mer_mul #(
    parameter int OP_W   = 22,
    parameter int PROD_W = 48
) (
    input  logic              clk,
    input  logic [OP_W-1:0]   a,
    input  logic [OP_W-1:0]   b,
    output logic [PROD_W-1:0] prod
);

    logic [2*OP_W-1:0] full_prod;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign full_prod = a * b;
    assign prod_next = PROD_W'(full_prod);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// File: src/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasteriser: top level with sequencer, decision datapath and APB port.
// Depends on mer_pkg, the channel interfaces in mer_if and the shared multiplier mer_mul.
//
// Usage. The radii are written through the APB port (radius_x at byte 0, radius_y at
// byte 4) while the block is idle. Each transaction on in_ch carries start_req: a one
// restarts the ellipse and returns the top point (0, radius_y); a zero advances one
// step and returns the four symmetric points (x,y), (x,-y), (-x,-y), (-x,y), with last
// on the fourth. Once y has reached zero, every advance returns (0,0) with last and
// done_res set. An advance before any start returns nothing.
// Timing. One item is worked at a time; in_ch.ready is high only while the sequencer
// is idle. Every item first squares both radii on the single shared multiplier, then
// a step updates the coordinates and slopes and then the decision, and the output
// register hands out one point per cycle while out_ch.ready is high. The step that
// enters region 2 takes longer, as the region-2 decision is rebuilt from three
// squares on the same multiplier.
// Reset puts the radii at 200 and 100, the phase at idle and drops out_ch.valid.
// When the receiver stalls, the current point holds in the output register and the
// sequencer waits; no result is lost or repeated.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mer_pkg::ADDR_W-1:0]     paddr,
    input  logic [mer_pkg::DATA_W-1:0]     pwdata,
    output logic [mer_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    mer_in_if.sink                         in_ch,
    mer_out_if.source                      out_ch
);

    // Widths: squares of a radius, slope terms 2*r^2*coord, multiplier operands
    // and the decision value, which wraps at DW bits, at most 64.
    localparam int PT_W = COORD_BITS + 1;
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int SL_W = 3 * COORD_BITS + 3;
    localparam int MW   = 2 * COORD_BITS + 2;
    localparam int DW   = (4 * COORD_BITS + 8 > 64) ? 64 : 4 * COORD_BITS + 8;

    typedef logic [DW-1:0] dec_t;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RX2  = 4'd1;
    localparam logic [3:0] S_RY2  = 4'd2;
    localparam logic [3:0] S_DISP = 4'd3;
    localparam logic [3:0] S_BR   = 4'd4;
    localparam logic [3:0] S_INIT = 4'd5;
    localparam logic [3:0] S_DUPD = 4'd6;
    localparam logic [3:0] S_R2A  = 4'd7;
    localparam logic [3:0] S_R2B  = 4'd8;
    localparam logic [3:0] S_R2C  = 4'd9;
    localparam logic [3:0] S_R2D  = 4'd10;
    localparam logic [3:0] S_R2E  = 4'd11;
    localparam logic [3:0] S_R2F  = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [COORD_BITS-1:0] radius_x_reg, radius_x_next;
    logic [COORD_BITS-1:0] radius_y_reg, radius_y_next;
    logic [3:0]            state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  req_reg, req_next;
    logic [SQ_W-1:0]       rx2_reg, rx2_next;
    logic [SQ_W-1:0]       ry2_reg, ry2_next;
    logic [PT_W-1:0]       cur_x_reg, cur_x_next;
    logic [PT_W-1:0]       cur_y_reg, cur_y_next;
    logic [SL_W-1:0]       sx_reg, sx_next;
    logic [SL_W-1:0]       sy_reg, sy_next;
    dec_t                  dec_reg, dec_next;
    logic                  flag_reg, flag_next;
    logic [1:0]            mode_reg, mode_next;
    logic [1:0]            k_reg, k_next;
    logic                  out_valid_reg, out_valid_next;

    logic signed [PT_W-1:0] pt_x_reg, pt_x_next;
    logic signed [PT_W-1:0] pt_y_reg, pt_y_next;
    logic                   last_reg, last_next;
    logic                   done_reg, done_next;

    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    dec_t            prod;
    logic [MW-1:0]   prod_op;
    logic [MW-1:0]   prod_dbl;
    logic            cfg_write;
    logic            dec_pos;
    logic            y_zero;
    logic            sx_below;
    dec_t            term;
    logic            load_pt;
    logic [1:0]      load_k;
    logic [PT_W-1:0] neg_x;
    logic [PT_W-1:0] neg_y;

    mer_mul #(
        .OP_W   (MW),
        .PROD_W (DW)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Configuration port: always ready, writes land on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[mer_pkg::REG_SEL_BIT])
            mer_pkg::REG_RADIUS_X: prdata = mer_pkg::DATA_W'(radius_x_reg);
            mer_pkg::REG_RADIUS_Y: prdata = mer_pkg::DATA_W'(radius_y_reg);
            default:               prdata = '0;
        endcase
    end

    // Decision sign test: a decision of exactly zero counts as not positive.
    assign dec_pos  = (dec_reg != '0) && !dec_reg[DW-1];
    assign y_zero   = (cur_y_reg == '0);
    assign sx_below = (sx_reg < sy_reg);
    assign prod_op  = prod[MW-1:0];
    assign prod_dbl = {prod[MW-2:0], 1'b0};

    // Increment of the decision, before the scaling by four. The slopes have
    // already been updated by the previous cycle, and flag_reg records which
    // optional move took place.
    always_comb
    begin
        if (phase_reg == mer_pkg::PH_REG1)
        begin
            term = dec_t'(ry2_reg) + dec_t'(sx_reg) - (flag_reg ? dec_t'(sy_reg) : '0);
        end
        else
        begin
            term = dec_t'(rx2_reg) - dec_t'(sy_reg) + (flag_reg ? dec_t'(sx_reg) : '0);
        end
    end

    always_comb
    begin
        radius_x_next  = radius_x_reg;
        radius_y_next  = radius_y_reg;
        state_next     = state_reg;
        phase_next     = phase_reg;
        req_next       = req_reg;
        rx2_next       = rx2_reg;
        ry2_next       = ry2_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        dec_next       = dec_reg;
        flag_next      = flag_reg;
        mode_next      = mode_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        load_pt        = 1'b0;
        load_k         = k_reg;

        if (cfg_write)
        begin
            unique case (paddr[mer_pkg::REG_SEL_BIT])
                mer_pkg::REG_RADIUS_X: radius_x_next = pwdata[COORD_BITS-1:0];
                mer_pkg::REG_RADIUS_Y: radius_y_next = pwdata[COORD_BITS-1:0];
                default:               radius_x_next = radius_x_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next   = in_ch.start_req;
                    state_next = S_RX2;
                end
            end
            S_RX2:
            begin
                mul_a      = MW'(radius_x_reg);
                mul_b      = MW'(radius_x_reg);
                state_next = S_RY2;
            end
            S_RY2:
            begin
                mul_a      = MW'(radius_y_reg);
                mul_b      = MW'(radius_y_reg);
                rx2_next   = prod[SQ_W-1:0];
                state_next = S_DISP;
            end
            S_DISP:
            begin
                ry2_next   = prod[SQ_W-1:0];
                state_next = S_BR;
            end
            S_BR:
            begin
                if (req_reg)
                begin
                    mul_a      = MW'(rx2_reg);
                    mul_b      = MW'(radius_y_reg);
                    state_next = S_INIT;
                end
                else
                begin
                    case (phase_reg)
                        mer_pkg::PH_IDLE:
                        begin
                            state_next = S_IDLE;
                        end
                        mer_pkg::PH_DONE:
                        begin
                            mode_next  = mer_pkg::MODE_END;
                            state_next = S_EMIT;
                        end
                        mer_pkg::PH_REG1:
                        begin
                            if (sx_below)
                            begin
                                cur_x_next = cur_x_reg + PT_W'(1);
                                sx_next    = sx_reg + SL_W'({ry2_reg, 1'b0});
                                if (dec_pos)
                                begin
                                    cur_y_next = cur_y_reg - PT_W'(1);
                                    sy_next    = sy_reg - SL_W'({rx2_reg, 1'b0});
                                end
                                flag_next  = dec_pos;
                                state_next = S_DUPD;
                            end
                            else
                            begin
                                // Rebuild the decision for region 2 from
                                // (ry*(2x+1))^2 + (2*rx*(y-1))^2 - (2*rx*ry)^2.
                                mul_a      = MW'(radius_y_reg);
                                mul_b      = MW'({cur_x_reg, 1'b1});
                                state_next = S_R2A;
                            end
                        end
                        default:
                        begin
                            if (y_zero)
                            begin
                                phase_next = mer_pkg::PH_DONE;
                                mode_next  = mer_pkg::MODE_END;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cur_y_next = cur_y_reg - PT_W'(1);
                                sy_next    = sy_reg - SL_W'({rx2_reg, 1'b0});
                                if (!dec_pos)
                                begin
                                    cur_x_next = cur_x_reg + PT_W'(1);
                                    sx_next    = sx_reg + SL_W'({ry2_reg, 1'b0});
                                end
                                flag_next  = !dec_pos;
                                state_next = S_DUPD;
                            end
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                // prod holds rx^2 * ry here.
                cur_x_next = '0;
                cur_y_next = PT_W'(radius_y_reg);
                sx_next    = '0;
                sy_next    = SL_W'(prod << 1);
                dec_next   = (dec_t'(ry2_reg) << 2) - (prod << 2) + dec_t'(rx2_reg);
                phase_next = (radius_y_reg == '0) ? mer_pkg::PH_DONE : mer_pkg::PH_REG1;
                mode_next  = mer_pkg::MODE_TOP;
                state_next = S_EMIT;
            end
            S_DUPD:
            begin
                dec_next   = dec_reg + (term << 2);
                if (y_zero)
                begin
                    phase_next = mer_pkg::PH_DONE;
                end
                mode_next  = mer_pkg::MODE_QUAD;
                state_next = S_EMIT;
            end
            S_R2A:
            begin
                mul_a      = prod_op;
                mul_b      = prod_op;
                state_next = S_R2B;
            end
            S_R2B:
            begin
                dec_next   = prod;
                mul_a      = MW'(radius_x_reg);
                mul_b      = MW'(cur_y_reg - PT_W'(1));
                state_next = S_R2C;
            end
            S_R2C:
            begin
                mul_a      = prod_dbl;
                mul_b      = prod_dbl;
                state_next = S_R2D;
            end
            S_R2D:
            begin
                dec_next   = dec_reg + prod;
                mul_a      = MW'(radius_x_reg);
                mul_b      = MW'(radius_y_reg);
                state_next = S_R2E;
            end
            S_R2E:
            begin
                mul_a      = prod_dbl;
                mul_b      = prod_dbl;
                state_next = S_R2F;
            end
            S_R2F:
            begin
                dec_next   = dec_reg - prod;
                phase_next = mer_pkg::PH_REG2;
                state_next = S_BR;
            end
            S_EMIT:
            begin
                load_pt        = 1'b1;
                load_k         = mer_pkg::Q_PP;
                k_next         = mer_pkg::Q_PP;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    if (last_reg)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + 2'd1;
                        load_k  = k_reg + 2'd1;
                        load_pt = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Next point for the output register.
    assign neg_x = '0 - cur_x_reg;
    assign neg_y = '0 - cur_y_reg;

    always_comb
    begin
        pt_x_next = '0;
        pt_y_next = '0;
        last_next = 1'b1;
        done_next = 1'b1;
        case (mode_reg)
            mer_pkg::MODE_TOP:
            begin
                pt_x_next = cur_x_reg;
                pt_y_next = cur_y_reg;
                done_next = y_zero;
            end
            mer_pkg::MODE_QUAD:
            begin
                done_next = y_zero;
                case (load_k)
                    mer_pkg::Q_PP:
                    begin
                        pt_x_next = cur_x_reg;
                        pt_y_next = cur_y_reg;
                        last_next = 1'b0;
                    end
                    mer_pkg::Q_PN:
                    begin
                        pt_x_next = cur_x_reg;
                        pt_y_next = neg_y;
                        last_next = 1'b0;
                    end
                    mer_pkg::Q_NN:
                    begin
                        pt_x_next = neg_x;
                        pt_y_next = neg_y;
                        last_next = 1'b0;
                    end
                    default:
                    begin
                        pt_x_next = neg_x;
                        pt_y_next = cur_y_reg;
                        last_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                pt_x_next = '0;
                pt_y_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg  <= COORD_BITS'(200);
            radius_y_reg  <= COORD_BITS'(100);
            state_reg     <= S_IDLE;
            phase_reg     <= mer_pkg::PH_IDLE;
            req_reg       <= 1'b0;
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            dec_reg       <= '0;
            flag_reg      <= 1'b0;
            mode_reg      <= mer_pkg::MODE_END;
            k_reg         <= mer_pkg::Q_PP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            radius_x_reg  <= radius_x_next;
            radius_y_reg  <= radius_y_next;
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            req_reg       <= req_next;
            rx2_reg       <= rx2_next;
            ry2_reg       <= ry2_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            dec_reg       <= dec_next;
            flag_reg      <= flag_next;
            mode_reg      <= mode_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register; it only changes when a new point is loaded.
    always_ff @(posedge clk)
    begin
        if (load_pt)
        begin
            pt_x_reg <= pt_x_next;
            pt_y_reg <= pt_y_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.point_x  = pt_x_reg;
    assign out_ch.point_y  = pt_y_reg;
    assign out_ch.last     = last_reg;
    assign out_ch.done_res = done_reg;

    // The block never takes a new request while a result is still on offer.
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid)
        else $error("request accepted while a result is pending");

    // A run ends with its last point: valid drops straight after it is taken.
    a_last_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
        else $error("result still offered after the last point of the run");

    // A completed ellipse is only reported on the x axis.
    a_done_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.done_res) |-> (out_ch.point_y == '0))
        else $error("done reported away from y equal to zero");

    // Rebuilding the decision always leaves the sequencer in region 2.
    a_reg2_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R2F) |=> (phase_reg == mer_pkg::PH_REG2 && state_reg == S_BR))
        else $error("region 2 entry did not switch the phase");

endmodule
